// ----- design/cbc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cbc_pkg;

	localparam int SQ_STAGES  = 16;
	localparam int DIV_STAGES = 8;
	localparam logic [15:0] ONE_Q14 = 16'd16384;

	typedef struct packed {
		logic signed [31:0] circle_x;
		logic signed [31:0] circle_y;
		logic [30:0]        radius;
		logic signed [31:0] box_x;
		logic signed [31:0] box_y;
		logic [30:0]        box_width;
		logic [30:0]        box_height;
	} cbc_in_t;

	typedef struct packed {
		logic               colliding;
		logic [30:0]        penetration;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
	} cbc_out_t;

	typedef struct packed {
		logic        hit;
		logic        zero;
		logic [30:0] radius;
		logic        neg_x;
		logic        neg_y;
		logic [31:0] ax;
		logic [31:0] ay;
	} cbc_meta_t;

	typedef struct packed {
		logic        hit;
		logic        zero;
		logic        neg;
		logic [30:0] pen;
	} cbc_tail_t;

	typedef struct packed {
		logic [34:0] rem;
		logic [31:0] root;
	} cbc_sq_t;

	typedef struct packed {
		logic [31:0] rem;
		logic        qbit;
	} cbc_dv_t;

	function automatic cbc_sq_t sqrt_step(input logic [34:0] rem, input logic [31:0] root,
			input logic [1:0] b);
		logic [34:0] r;
		logic [34:0] trial;
		cbc_sq_t     res;
		r     = {rem[32:0], b};
		trial = {1'b0, root, 2'b01};
		if (r >= trial) begin
			res.rem  = r - trial;
			res.root = {root[30:0], 1'b1};
		end else begin
			res.rem  = r;
			res.root = {root[30:0], 1'b0};
		end
		return res;
	endfunction

	function automatic cbc_dv_t div_step(input logic [31:0] rem, input logic [31:0] den,
			input logic b);
		logic [32:0] r;
		cbc_dv_t     res;
		r = {rem, b};
		if (r >= {1'b0, den}) begin
			r        = r - {1'b0, den};
			res.qbit = 1'b1;
		end else begin
			res.qbit = 1'b0;
		end
		res.rem = r[31:0];
		return res;
	endfunction

endpackage

`default_nettype wire

// ----- design/cbc_chan_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface cbc_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/cbc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cbc_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire cbc_pkg::cbc_in_t in_data,
	output logic                 out_valid,
	output logic [63:0]          dsq,
	output cbc_pkg::cbc_meta_t   out_meta
);

	function automatic logic signed [34:0] axis_off(input logic signed [31:0] c,
			input logic signed [31:0] b, input logic [30:0] s);
		logic signed [34:0] c2;
		logic signed [34:0] b2;
		logic signed [34:0] s2;
		logic signed [34:0] lo;
		logic signed [34:0] hi;
		logic signed [34:0] near;
		c2 = {{2{c[31]}}, c, 1'b0};
		b2 = {{2{b[31]}}, b, 1'b0};
		s2 = {4'b0, s};
		lo = b2 - s2;
		hi = b2 + s2;
		if (c2 < lo)
			near = lo;
		else if (c2 > hi)
			near = hi;
		else
			near = c2;
		return c2 - near;
	endfunction

	logic signed [34:0] dx, dy;
	logic [34:0]        abs_x, abs_y;
	logic               v_s1, v_s2, v_s3;
	logic [31:0]        ax_s1, ay_s1;
	logic               far_s1, far_s2;
	logic               neg_x_s1, neg_y_s1, neg_x_s2, neg_y_s2;
	logic [30:0]        radius_s1, radius_s2;
	logic [63:0]        sx_s2, sy_s2, rr_s2;
	logic [31:0]        ax_s2, ay_s2;
	logic [64:0]        sum;
	logic [63:0]        dsq_s3;
	cbc_pkg::cbc_meta_t meta_s3;

	always_comb begin
		dx    = axis_off(in_data.circle_x, in_data.box_x, in_data.box_width);
		dy    = axis_off(in_data.circle_y, in_data.box_y, in_data.box_height);
		abs_x = dx[34] ? 35'(-dx) : 35'(dx);
		abs_y = dy[34] ? 35'(-dy) : 35'(dy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign sum = {1'b0, sx_s2} + {1'b0, sy_s2};

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1     <= abs_x[31:0];
			ay_s1     <= abs_y[31:0];
			far_s1    <= (abs_x > {3'b0, in_data.radius, 1'b0}) ||
				(abs_y > {3'b0, in_data.radius, 1'b0});
			neg_x_s1  <= !dx[34] && (dx != '0);
			neg_y_s1  <= !dy[34] && (dy != '0);
			radius_s1 <= in_data.radius;

			sx_s2     <= 64'(ax_s1) * 64'(ax_s1);
			sy_s2     <= 64'(ay_s1) * 64'(ay_s1);
			rr_s2     <= 64'({radius_s1, 1'b0}) * 64'({radius_s1, 1'b0});
			far_s2    <= far_s1;
			neg_x_s2  <= neg_x_s1;
			neg_y_s2  <= neg_y_s1;
			radius_s2 <= radius_s1;
			ax_s2     <= ax_s1;
			ay_s2     <= ay_s1;

			dsq_s3         <= sum[63:0];
			meta_s3.hit    <= !far_s2 && (sum <= {1'b0, rr_s2});
			meta_s3.zero   <= (sum == '0);
			meta_s3.radius <= radius_s2;
			meta_s3.neg_x  <= neg_x_s2;
			meta_s3.neg_y  <= neg_y_s2;
			meta_s3.ax     <= ax_s2;
			meta_s3.ay     <= ay_s2;
		end
	end

	assign out_valid = v_s3;
	assign dsq       = dsq_s3;
	assign out_meta  = meta_s3;

endmodule

`default_nettype wire

// ----- design/cbc_isqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cbc_isqrt (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire logic [63:0]     rad,
	input  wire cbc_pkg::cbc_meta_t in_meta,
	output logic                 out_valid,
	output logic [31:0]          root,
	output cbc_pkg::cbc_meta_t   out_meta
);

	localparam int N = cbc_pkg::SQ_STAGES;

	logic               v_s    [N];
	logic [63:0]        bits_s [N];
	logic [34:0]        rem_s  [N];
	logic [31:0]        root_s [N];
	cbc_pkg::cbc_meta_t meta_s [N];

	for (genvar g = 0; g < N; g++) begin : g_stage
		logic               v_in;
		logic [63:0]        bits_in;
		logic [34:0]        rem_in;
		logic [31:0]        root_in;
		cbc_pkg::cbc_meta_t meta_in;
		cbc_pkg::cbc_sq_t   a, b;

		if (g == 0) begin : g_first
			assign v_in    = in_valid;
			assign bits_in = rad;
			assign rem_in  = '0;
			assign root_in = '0;
			assign meta_in = in_meta;
		end else begin : g_next
			assign v_in    = v_s[g-1];
			assign bits_in = bits_s[g-1];
			assign rem_in  = rem_s[g-1];
			assign root_in = root_s[g-1];
			assign meta_in = meta_s[g-1];
		end

		always_comb begin
			a = cbc_pkg::sqrt_step(rem_in, root_in, bits_in[63:62]);
			b = cbc_pkg::sqrt_step(a.rem, a.root, bits_in[61:60]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				bits_s[g] <= {bits_in[59:0], 4'b0};
				rem_s[g]  <= b.rem;
				root_s[g] <= b.root;
				meta_s[g] <= meta_in;
			end
		end
	end

	assign out_valid = v_s[N-1];
	assign root      = root_s[N-1];
	assign out_meta  = meta_s[N-1];

endmodule

`default_nettype wire

// ----- design/cbc_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cbc_div (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire logic [47:0]     num,
	input  wire logic [31:0]     den,
	input  wire cbc_pkg::cbc_tail_t in_tail,
	output logic                 out_valid,
	output logic [15:0]          quo,
	output cbc_pkg::cbc_tail_t   out_tail
);

	localparam int N = cbc_pkg::DIV_STAGES;

	logic               v_s    [N];
	logic [15:0]        low_s  [N];
	logic [31:0]        rem_s  [N];
	logic [31:0]        den_s  [N];
	cbc_pkg::cbc_tail_t tail_s [N];

	for (genvar g = 0; g < N; g++) begin : g_stage
		logic               v_in;
		logic [15:0]        low_in;
		logic [31:0]        rem_in;
		logic [31:0]        den_in;
		cbc_pkg::cbc_tail_t tail_in;
		cbc_pkg::cbc_dv_t   a, b;

		if (g == 0) begin : g_first
			assign v_in    = in_valid;
			assign low_in  = num[15:0];
			assign rem_in  = num[47:16];
			assign den_in  = den;
			assign tail_in = in_tail;
		end else begin : g_next
			assign v_in    = v_s[g-1];
			assign low_in  = low_s[g-1];
			assign rem_in  = rem_s[g-1];
			assign den_in  = den_s[g-1];
			assign tail_in = tail_s[g-1];
		end

		always_comb begin
			a = cbc_pkg::div_step(rem_in, den_in, low_in[15]);
			b = cbc_pkg::div_step(a.rem, den_in, low_in[14]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= v_in;
			end
		end

		// low bits shift out at the top while quotient bits enter at the bottom
		always_ff @(posedge clk) begin
			if (en) begin
				low_s[g]  <= {low_in[13:0], a.qbit, b.qbit};
				rem_s[g]  <= b.rem;
				den_s[g]  <= den_in;
				tail_s[g] <= tail_in;
			end
		end
	end

	assign out_valid = v_s[N-1];
	assign quo       = low_s[N-1];
	assign out_tail  = tail_s[N-1];

endmodule

`default_nettype wire

// ----- design/circle_box_contact.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Circle versus axis-aligned box contact tester. One circle/box pair is taken per
// cycle while the result side does not stall. Its result passes through 3 stages
// of offset, square and compare, 16 stages of square root at two root bits each,
// one stage forming the dividends, 8 stages of restoring division at two quotient
// bits each for the two normal components side by side, and the output register.
// A stall on the result side holds the whole pipeline, so shape.ready follows
// contact.ready whenever a result is waiting.

module circle_box_contact (
	input  wire logic clk,
	input  wire logic arst_n,
	cbc_chan_if.sink   shape,
	cbc_chan_if.source contact
);

	logic               en;
	logic               out_v_q;
	cbc_pkg::cbc_out_t  out_q;

	logic               fr_valid;
	logic [63:0]        fr_dsq;
	cbc_pkg::cbc_meta_t fr_meta;

	logic               sq_valid;
	logic [31:0]        sq_root;
	cbc_pkg::cbc_meta_t sq_meta;

	logic               v_prep_s;
	logic [47:0]        num_x_s, num_y_s;
	logic [31:0]        den_s;
	cbc_pkg::cbc_tail_t tail_x_s, tail_y_s;
	logic [31:0]        pen_diff;

	logic               dx_valid, dy_valid;
	logic [15:0]        qx, qy;
	cbc_pkg::cbc_tail_t tx, ty;
	logic [15:0]        mag_x, mag_y;
	cbc_pkg::cbc_out_t  res;

	assign en          = !out_v_q || contact.ready;
	assign shape.ready = en;

	cbc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (shape.valid),
		.in_data  (shape.data),
		.out_valid(fr_valid),
		.dsq      (fr_dsq),
		.out_meta (fr_meta)
	);

	cbc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (fr_valid),
		.rad      (fr_dsq),
		.in_meta  (fr_meta),
		.out_valid(sq_valid),
		.root     (sq_root),
		.out_meta (sq_meta)
	);

	assign pen_diff = {sq_meta.radius, 1'b0} - sq_root;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_prep_s <= 1'b0;
		end else if (en) begin
			v_prep_s <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_x_s <= {2'b0, sq_meta.ax, 14'b0} + 48'(sq_root[31:1]);
			num_y_s <= {2'b0, sq_meta.ay, 14'b0} + 48'(sq_root[31:1]);
			den_s   <= sq_root;
			tail_x_s.hit  <= sq_meta.hit;
			tail_x_s.zero <= sq_meta.zero;
			tail_x_s.neg  <= sq_meta.neg_x;
			tail_x_s.pen  <= !sq_meta.hit ? '0 :
				(sq_meta.zero ? sq_meta.radius : pen_diff[31:1]);
			tail_y_s.hit  <= sq_meta.hit;
			tail_y_s.zero <= sq_meta.zero;
			tail_y_s.neg  <= sq_meta.neg_y;
			tail_y_s.pen  <= '0;
		end
	end

	cbc_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_prep_s),
		.num      (num_x_s),
		.den      (den_s),
		.in_tail  (tail_x_s),
		.out_valid(dx_valid),
		.quo      (qx),
		.out_tail (tx)
	);

	cbc_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_prep_s),
		.num      (num_y_s),
		.den      (den_s),
		.in_tail  (tail_y_s),
		.out_valid(dy_valid),
		.quo      (qy),
		.out_tail (ty)
	);

	always_comb begin
		mag_x = (qx > cbc_pkg::ONE_Q14) ? cbc_pkg::ONE_Q14 : qx;
		mag_y = (qy > cbc_pkg::ONE_Q14) ? cbc_pkg::ONE_Q14 : qy;
		res.colliding   = tx.hit;
		res.penetration = tx.pen;
		if (!tx.hit) begin
			res.normal_x = '0;
			res.normal_y = '0;
		end else if (tx.zero) begin
			res.normal_x = cbc_pkg::ONE_Q14;
			res.normal_y = '0;
		end else begin
			res.normal_x = tx.neg ? -mag_x : mag_x;
			res.normal_y = ty.neg ? -mag_y : mag_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= dx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= res;
		end
	end

	assign contact.valid = out_v_q;
	assign contact.data  = out_q;

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		dx_valid == dy_valid)
		else $error("normal lanes out of step");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(contact.valid && !contact.data.colliding) |->
		(contact.data.penetration == '0 && contact.data.normal_x == '0 &&
		contact.data.normal_y == '0))
		else $error("miss carries nonzero contact data");

	a_normal_range: assert property (@(posedge clk) disable iff (!arst_n)
		contact.valid |->
		($signed(contact.data.normal_x) <= 16'sd16384 &&
		$signed(contact.data.normal_x) >= -16'sd16384 &&
		$signed(contact.data.normal_y) <= 16'sd16384 &&
		$signed(contact.data.normal_y) >= -16'sd16384))
		else $error("normal component out of range");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(contact.valid && !contact.ready) |-> !shape.ready)
		else $error("input taken while result stalled");

endmodule

`default_nettype wire
